### hdl/avr3_pkg.sv
// Shared constants for the 3D axis vector rotation core.
// Holds the CORDIC arctangent table, the gain correction constant and the guard width.
// No dependencies.
package avr3_pkg;

  localparam int GUARD_BITS = 12;

  // Inverse CORDIC gain, unsigned Q32
  localparam logic [31:0] GAIN_INV_Q32 = 32'h9B74EDA8;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

### hdl/avr3_cell.sv
// One CORDIC rotation stage: a micro-rotation by +/- atan(2^-IDX), registered.
// Carries the request's side band alongside. Uses avr3_pkg.
module avr3_cell #(
  parameter int W   = 47,
  parameter int SBW = 98,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a_in,
  input  logic signed [W-1:0] b_in,
  input  logic [31:0]         z_in,
  input  logic [SBW-1:0]      sb_in,
  output logic signed [W-1:0] a_out,
  output logic signed [W-1:0] b_out,
  output logic [31:0]         z_out,
  output logic [SBW-1:0]      sb_out
);
  import avr3_pkg::*;

  logic signed [W-1:0] da, db;
  logic signed [W-1:0] a_nxt, b_nxt;
  logic [31:0]         z_nxt;
  logic signed [W-1:0] a_r, b_r;
  logic [31:0]         z_r;
  logic [SBW-1:0]      sb_r;

  always_comb begin
    da = b_in >>> IDX;
    db = a_in >>> IDX;
    // drive the residual angle toward zero
    if (!z_in[31]) begin
      a_nxt = a_in - da;
      b_nxt = b_in + db;
      z_nxt = z_in - ATAN_TURN[IDX];
    end else begin
      a_nxt = a_in + da;
      b_nxt = b_in - db;
      z_nxt = z_in + ATAN_TURN[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      z_r  <= z_nxt;
      sb_r <= sb_in;
    end
  end

  assign a_out  = a_r;
  assign b_out  = b_r;
  assign z_out  = z_r;
  assign sb_out = sb_r;

endmodule

### hdl/avr3_fin.sv
// Gain correction, rounding and saturation of one rotated coordinate, four stages.
// Magnitude, Q32 gain multiply split in two 32-bit halves, sum, round and clip. Uses avr3_pkg.
module avr3_fin #(
  parameter int CW = 32,
  parameter int W  = 47
) (
  input  logic                clk,
  input  logic [3:0]          en,
  input  logic signed [W-1:0] v_in,
  output logic [CW-1:0]       res,
  output logic                sat
);
  import avr3_pkg::*;

  localparam logic [63:0] HALF   = 64'd1 << (GUARD_BITS - 1);
  localparam logic [63:0] NEGLIM = 64'd1 << (CW - 1);
  localparam logic [63:0] POSLIM = NEGLIM - 64'd1;

  logic [W-1:0]  m_nxt, m_r;
  logic          neg0_r, neg1_r, neg2_r;
  logic [63:0]   m64;
  logic [63:0]   ph_nxt, pl_nxt, ph_r, pl_r;
  logic [63:0]   q_nxt, q_r;
  logic [63:0]   rnd;
  logic [CW-1:0] res_nxt, res_r;
  logic          sat_nxt, sat_r;

  always_comb begin
    m_nxt  = v_in[W-1] ? (W'(0) - $unsigned(v_in)) : $unsigned(v_in);
    m64    = 64'(m_r);
    ph_nxt = 64'(m64[63:32]) * 64'(GAIN_INV_Q32);
    pl_nxt = 64'(m64[31:0]) * 64'(GAIN_INV_Q32);
    q_nxt  = ph_r + (pl_r >> 32);
    rnd    = (q_r + HALF) >> GUARD_BITS;
    sat_nxt = 1'b0;
    // round half away from zero, then clip to the coordinate range
    if (neg2_r) begin
      if (rnd > NEGLIM) begin
        res_nxt = CW'(NEGLIM);
        sat_nxt = 1'b1;
      end else begin
        res_nxt = CW'(64'd0 - rnd);
      end
    end else begin
      if (rnd > POSLIM) begin
        res_nxt = CW'(POSLIM);
        sat_nxt = 1'b1;
      end else begin
        res_nxt = CW'(rnd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r    <= m_nxt;
      neg0_r <= v_in[W-1];
    end
    if (en[1]) begin
      ph_r   <= ph_nxt;
      pl_r   <= pl_nxt;
      neg1_r <= neg0_r;
    end
    if (en[2]) begin
      q_r    <= q_nxt;
      neg2_r <= neg1_r;
    end
    if (en[3]) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

### hdl/axis_vector_rotation_3d_core.sv
// Top level of the 3D axis vector rotation core: quadrant fold, CORDIC cell chain,
// gain correction and output selection. Uses avr3_pkg, avr3_cell and avr3_fin.
//
//   channel   handshake            payload
//   input     in_valid/in_ready    in_axis, in_turn_angle, in_x, in_y, in_z
//   result    out_valid/out_ready  out_x, out_y, out_z, out_saturated
//
// One request per cycle while out_ready is high. The stages are the fold stage, one cell per
// CORDIC stage and four gain/round stages, the last stage being the output register.
// Reset (rst_n low, synchronous) clears every stage's valid bit; data registers are not reset.
// Each stage advances when it is empty or its successor advances, so bubbles close up
// while out_ready is low and new requests enter until the chain is full.
module axis_vector_rotation_3d_core #(
  parameter int COORD_WIDTH   = 32,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_axis,
  input  logic signed [ANGLE_WIDTH-1:0] in_turn_angle,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          out_saturated
);
  import avr3_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int S   = CORDIC_STAGES;
  localparam int W   = CW + GUARD_BITS + 3;
  localparam int SBW = 3 * CW + 2;
  localparam int L   = S + 5;

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z, AXIS_NONE} axis_t;

  logic [L:0]   adv;
  logic [L-1:0] v_r, v_nxt;

  // fold stage
  axis_t               ax_in;
  logic [31:0]         ang32;
  logic                fold;
  logic [CW-1:0]       pa, pb;
  logic signed [W-1:0] ea, eb;
  logic signed [W-1:0] a0_nxt, b0_nxt, a0_r, b0_r;
  logic [31:0]         z0_nxt, z0_r;
  logic [SBW-1:0]      sb0_r;

  logic signed [W-1:0] a_s [S+1];
  logic signed [W-1:0] b_s [S+1];
  logic [31:0]         z_s [S+1];
  logic [SBW-1:0]      sb_s [S+1];
  logic [SBW-1:0]      sbf_r [4];

  logic [CW-1:0] ra, rb;
  logic          sa, sb;
  axis_t         ax_out;
  logic [CW-1:0] ox, oy, oz;

  // stage advance chain
  assign adv[L] = out_ready;
  for (genvar k = 0; k < L; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end

  always_comb begin
    v_nxt = v_r;
    for (int k = 0; k < L; k++) begin
      if (adv[k]) v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[L-1];

  always_comb begin
    ax_in = axis_t'(in_axis);
    unique case (ax_in)
      AXIS_X: begin
        pa = in_y;
        pb = in_z;
      end
      AXIS_Y: begin
        pa = in_z;
        pb = in_x;
      end
      AXIS_Z, AXIS_NONE: begin
        pa = in_x;
        pb = in_y;
      end
      default: begin
        pa = in_x;
        pb = in_y;
      end
    endcase
    ang32 = {in_turn_angle, {(32-ANGLE_WIDTH){1'b0}}};
    // second and third quadrant: rotate by pi and negate both coordinates
    fold  = ang32[31] ^ ang32[30];
    ea    = {{(W-CW-GUARD_BITS){pa[CW-1]}}, pa, {GUARD_BITS{1'b0}}};
    eb    = {{(W-CW-GUARD_BITS){pb[CW-1]}}, pb, {GUARD_BITS{1'b0}}};
    a0_nxt = fold ? -ea : ea;
    b0_nxt = fold ? -eb : eb;
    z0_nxt = {ang32[31] ^ fold, ang32[30:0]};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a0_r  <= a0_nxt;
      b0_r  <= b0_nxt;
      z0_r  <= z0_nxt;
      sb0_r <= {in_axis, in_x, in_y, in_z};
    end
  end

  assign a_s[0]  = a0_r;
  assign b_s[0]  = b0_r;
  assign z_s[0]  = z0_r;
  assign sb_s[0] = sb0_r;

  for (genvar i = 0; i < S; i++) begin : g_cell
    avr3_cell #(
      .W   (W),
      .SBW (SBW),
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .en     (adv[i+1]),
      .a_in   (a_s[i]),
      .b_in   (b_s[i]),
      .z_in   (z_s[i]),
      .sb_in  (sb_s[i]),
      .a_out  (a_s[i+1]),
      .b_out  (b_s[i+1]),
      .z_out  (z_s[i+1]),
      .sb_out (sb_s[i+1])
    );
  end

  avr3_fin #(.CW(CW), .W(W)) u_fin_a (
    .clk  (clk),
    .en   (adv[S+4:S+1]),
    .v_in (a_s[S]),
    .res  (ra),
    .sat  (sa)
  );

  avr3_fin #(.CW(CW), .W(W)) u_fin_b (
    .clk  (clk),
    .en   (adv[S+4:S+1]),
    .v_in (b_s[S]),
    .res  (rb),
    .sat  (sb)
  );

  // side band follows the gain stages
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      if (adv[S+1+j]) sbf_r[j] <= (j == 0) ? sb_s[S] : sbf_r[(j == 0) ? 0 : j-1];
    end
  end

  always_comb begin
    ax_out = axis_t'(sbf_r[3][SBW-1 -: 2]);
    ox = sbf_r[3][3*CW-1 -: CW];
    oy = sbf_r[3][2*CW-1 -: CW];
    oz = sbf_r[3][CW-1:0];
    out_saturated = sa | sb;
    unique case (ax_out)
      AXIS_X: begin
        oy = ra;
        oz = rb;
      end
      AXIS_Y: begin
        oz = ra;
        ox = rb;
      end
      AXIS_Z: begin
        ox = ra;
        oy = rb;
      end
      AXIS_NONE: begin
        out_saturated = 1'b0;
      end
      default: begin
        out_saturated = 1'b0;
      end
    endcase
    out_x = ox;
    out_y = oy;
    out_z = oz;
  end

endmodule
